/* rtl/ple_pkg.sv */
// ple_pkg: shared types and constants for the positional list engine.
// No dependencies.
package ple_pkg;

  localparam int PLE_CAPACITY = 256;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 9;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef struct packed {
    logic              done;
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  list_count;
    logic              is_empty;
  } res_t;

endpackage

/* rtl/ple_mem.sv */
// ple_mem: entry store, one write port and one read port with registered read data.
// Depends on nothing beyond its parameters.
module ple_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/ple_ctrl.sv */
// ple_ctrl: sequencer for get, locate, insert and delete; walks the store one entry a cycle.
// Depends on ple_pkg; drives the ports of ple_mem.
module ple_ctrl import ple_pkg::*; #(
  parameter  int CAPACITY = PLE_CAPACITY,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] item_value,
  output logic              busy,
  output res_t              res,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [DATA_W-1:0] wr_data,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [DATA_W-1:0] rd_data
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE, S_GET, S_LOC, S_INS, S_PUT, S_DEL0, S_DEL
  } state_t;

  state_t            state;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     at;
  logic [DATA_W-1:0] val_r;
  logic [CW-1:0]     count;
  logic              done;
  logic              ok_r;
  logic [DATA_W-1:0] rv_r;
  logic [POS_W-1:0]  fp_r;

  logic              in_range;
  logic              has_room;
  logic [AW-1:0]     at_in;
  logic [AW-1:0]     last;
  logic [AW-1:0]     idx_inc;
  logic [AW-1:0]     idx_dec;
  logic              idx_is_last;
  logic              match;
  op_t               op_in;

  assign op_in       = op_t'(req_type);
  assign in_range    = (position != '0) && (CMPW'(position) <= CMPW'(count));
  assign has_room    = count < CW'(CAPACITY);
  assign at_in       = AW'(position - POS_W'(1));
  assign last        = AW'(count - CW'(1));
  assign idx_inc     = idx + AW'(1);
  assign idx_dec     = idx - AW'(1);
  assign idx_is_last = (CW'(idx) + CW'(1)) == count;
  assign match       = rd_data == val_r;
  assign busy        = state != S_IDLE;

  assign res.done           = done;
  assign res.ok             = ok_r;
  assign res.read_value     = rv_r;
  assign res.found_position = fp_r;
  assign res.list_count     = POS_W'(count);
  assign res.is_empty       = count == '0;

  // memory requests
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_inc;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op_in)
            OP_GET: begin
              rd_en   = in_range;
              rd_addr = at_in;
            end
            OP_LOCATE: begin
              rd_en   = count != '0;
              rd_addr = '0;
            end
            OP_INSERT: begin
              if (has_room && position == '0) begin
                wr_en   = 1'b1;
                wr_addr = AW'(count);
                wr_data = item_value;
              end else begin
                rd_en   = has_room && in_range;
                rd_addr = last;
              end
            end
            OP_DELETE: begin
              rd_en   = in_range;
              rd_addr = at_in;
            end
          endcase
        end
      end
      S_LOC: begin
        rd_en = !match && !idx_is_last;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc;
        rd_en   = idx != at;
        rd_addr = idx_dec;
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_data = val_r;
      end
      S_DEL0: begin
        rd_en = !idx_is_last;
      end
      S_DEL: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec;
        rd_en   = !idx_is_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val_r <= item_value;
            ok_r  <= 1'b0;
            rv_r  <= '0;
            fp_r  <= '0;
            unique case (op_in)
              OP_GET: begin
                if (in_range) state <= S_GET;
                else          done  <= 1'b1;
              end
              OP_LOCATE: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= S_LOC;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_INSERT: begin
                if (has_room && position == '0) begin
                  count <= count + CW'(1);
                  ok_r  <= 1'b1;
                  done  <= 1'b1;
                end else if (has_room && in_range) begin
                  idx   <= last;
                  at    <= at_in;
                  state <= S_INS;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_DELETE: begin
                if (in_range) begin
                  idx   <= at_in;
                  state <= S_DEL0;
                end else begin
                  done <= 1'b1;
                end
              end
            endcase
          end
        end
        S_GET: begin
          rv_r  <= rd_data;
          ok_r  <= 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_LOC: begin
          if (match) begin
            ok_r  <= 1'b1;
            fp_r  <= POS_W'(CW'(idx) + CW'(1));
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (idx_is_last) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx_inc;
          end
        end
        S_INS: begin
          if (idx == at) state <= S_PUT;
          else           idx   <= idx_dec;
        end
        S_PUT: begin
          count <= count + CW'(1);
          ok_r  <= 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_DEL0, S_DEL: begin
          if (state == S_DEL0) rv_r <= rd_data;
          if (idx_is_last) begin
            count <= count - CW'(1);
            ok_r  <= 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_DEL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/positional_list_engine_top.sv */
// One request at a time: busy is high while the sequencer walks the store, one entry a cycle.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Reset clears the length to 0; store contents stay undefined, no clearing pass.
// Depends on ple_pkg, ple_ctrl, ple_mem.
module positional_list_engine_top import ple_pkg::*; #(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] item_value,
  output logic                     done,
  output logic                     ok,
  output logic signed [DATA_W-1:0] read_value,
  output logic [POS_W-1:0]         found_position,
  output logic [POS_W-1:0]         list_count,
  output logic                     is_empty
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  res_t              res;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_type   (req_type),
    .position   (position),
    .item_value (item_value),
    .busy       (busy),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  ple_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(DATA_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign done           = res.done;
  assign ok             = res.ok;
  assign read_value     = res.read_value;
  assign found_position = res.found_position;
  assign list_count     = res.list_count;
  assign is_empty       = res.is_empty;

endmodule

/* rtl/ple_checker.sv */
// ple_checker: port-level checks on the positional list engine, bound to the top level.
// Depends on ple_pkg.
module ple_checker import ple_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     done,
  input logic                     ok,
  input logic signed [DATA_W-1:0] read_value,
  input logic [POS_W-1:0]         found_position,
  input logic [POS_W-1:0]         list_count,
  input logic                     is_empty
);

  // length moves only with a result word
  a_count_with_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && list_count != $past(list_count)) |-> done)
    else $error("list_count changed without done");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && done) |->
      (list_count == $past(list_count) ||
       list_count == $past(list_count) + POS_W'(1) ||
       list_count == $past(list_count) - POS_W'(1)))
    else $error("list_count moved by more than one");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && done && !ok) |->
      (read_value == '0 && found_position == '0 && list_count == $past(list_count)))
    else $error("failed request changed state or returned data");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found_position != '0) |-> (ok && read_value == '0))
    else $error("found_position without ok");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (list_count == '0 && read_value == '0 || ok))
    else $error("empty flag inconsistent");

endmodule

bind positional_list_engine_top ple_checker u_chk (.*);
